>>> src/assert_macros.svh
// Assertion macros used by the checker file dsv_chk.sv.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off during reset
`define DSV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define DSV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/dsv_pkg.sv
// Types, codes and the step program of the DSA sign and verify sequencer.
// Used by the top level; depends on nothing.
package dsv_pkg;

	localparam int PC_W = 5;

	typedef enum logic [2:0] {
		OP_QUO,
		OP_REM,
		OP_MUL,
		OP_ADD,
		OP_POW,
		OP_INV,
		OP_DONE
	} op_t;

	typedef enum logic [3:0] {
		SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4, SRC_R5, SRC_R6, SRC_R7,
		SRC_P, SRC_Q, SRC_PM1, SRC_SEED, SRC_KEY, SRC_HASH, SRC_NONCE, SRC_NONE
	} src_t;

	typedef enum logic {
		MOD_P,
		MOD_Q
	} mod_sel_t;

	typedef enum logic [2:0] {
		OUT_NONE,
		OUT_R,
		OUT_S,
		OUT_W,
		OUT_U1,
		OUT_U2,
		OUT_V
	} out_sel_t;

	typedef enum logic [1:0] {
		REG_PRIME,
		REG_ORDER,
		REG_SEED,
		REG_KEY
	} reg_idx_t;

	typedef struct packed {
		op_t      op;
		src_t     a;
		src_t     b;
		mod_sel_t m;
		src_t     dst;
		out_sel_t o;
	} step_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_OPER,
		ST_EXEC,
		ST_DIV,
		ST_MUL,
		ST_POW_CHK,
		ST_POW_MUL,
		ST_POW_SQS,
		ST_POW_SQ,
		ST_INV_CHK,
		ST_INV_DIV,
		ST_INV_MUL,
		ST_WB,
		ST_ERR,
		ST_DONE
	} state_t;

	function automatic step_t prog_step(input logic [PC_W-1:0] pc);
		step_t s;
		case (pc)
			5'd0:  s = '{OP_QUO, SRC_PM1,   SRC_Q,     MOD_Q, SRC_R0, OUT_NONE};
			5'd1:  s = '{OP_REM, SRC_SEED,  SRC_P,     MOD_P, SRC_R1, OUT_NONE};
			5'd2:  s = '{OP_POW, SRC_R1,    SRC_R0,    MOD_P, SRC_R0, OUT_NONE};
			5'd3:  s = '{OP_POW, SRC_R0,    SRC_NONCE, MOD_P, SRC_R1, OUT_NONE};
			5'd4:  s = '{OP_REM, SRC_R1,    SRC_Q,     MOD_Q, SRC_R1, OUT_R};
			5'd5:  s = '{OP_REM, SRC_NONCE, SRC_Q,     MOD_Q, SRC_R2, OUT_NONE};
			5'd6:  s = '{OP_INV, SRC_R2,    SRC_NONE,  MOD_Q, SRC_R2, OUT_NONE};
			5'd7:  s = '{OP_REM, SRC_HASH,  SRC_Q,     MOD_Q, SRC_R3, OUT_NONE};
			5'd8:  s = '{OP_REM, SRC_KEY,   SRC_Q,     MOD_Q, SRC_R4, OUT_NONE};
			5'd9:  s = '{OP_MUL, SRC_R4,    SRC_R1,    MOD_Q, SRC_R4, OUT_NONE};
			5'd10: s = '{OP_ADD, SRC_R3,    SRC_R4,    MOD_Q, SRC_R4, OUT_NONE};
			5'd11: s = '{OP_MUL, SRC_R2,    SRC_R4,    MOD_Q, SRC_R2, OUT_S};
			5'd12: s = '{OP_INV, SRC_R2,    SRC_NONE,  MOD_Q, SRC_R4, OUT_W};
			5'd13: s = '{OP_MUL, SRC_R3,    SRC_R4,    MOD_Q, SRC_R3, OUT_U1};
			5'd14: s = '{OP_MUL, SRC_R1,    SRC_R4,    MOD_Q, SRC_R5, OUT_U2};
			5'd15: s = '{OP_POW, SRC_R0,    SRC_KEY,   MOD_P, SRC_R6, OUT_NONE};
			5'd16: s = '{OP_POW, SRC_R0,    SRC_R3,    MOD_P, SRC_R7, OUT_NONE};
			5'd17: s = '{OP_POW, SRC_R6,    SRC_R5,    MOD_P, SRC_R6, OUT_NONE};
			5'd18: s = '{OP_MUL, SRC_R7,    SRC_R6,    MOD_P, SRC_R7, OUT_NONE};
			5'd19: s = '{OP_REM, SRC_R7,    SRC_Q,     MOD_Q, SRC_R7, OUT_V};
			default: s = '{OP_DONE, SRC_NONE, SRC_NONE, MOD_P, SRC_R0, OUT_NONE};
		endcase
		return s;
	endfunction

endpackage

>>> src/dsv_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// Depends on nothing.
module dsv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

>>> src/dsv_div.sv
// Restoring divider, one quotient bit per cycle: quotient and remainder.
// Depends on nothing.
module dsv_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);
	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W:0]       rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     den_q;
	logic [W:0]       shifted;
	logic             ge;

	assign done    = busy_q && (cnt_q == CNT_W'(W));
	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign quo     = quo_q;
	assign rem     = rem_q[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q && !done) begin
			rem_q <= ge ? (shifted - {1'b0, den_q}) : shifted;
			quo_q <= {quo_q[W-2:0], ge};
		end
	end
endmodule

>>> src/dsv_mulmod.sv
// Bit-serial modular multiplier by add and double; operands below the modulus.
// Depends on nothing.
module dsv_mulmod #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic         done,
	output logic [W-1:0] prod
);
	logic         busy_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] m_q;
	logic [W-1:0] acc_q;

	function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
			input logic [W-1:0] md);
		logic [W-1:0] gap;
		gap = md - y;
		return (x >= gap) ? (x - gap) : (x + y);
	endfunction

	assign done = busy_q && (b_q == '0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
			acc_q <= '0;
		end else if (busy_q && !done) begin
			if (b_q[0]) begin
				acc_q <= add_mod(acc_q, a_q, m_q);
			end
			a_q <= add_mod(a_q, a_q, m_q);
			b_q <= b_q >> 1;
		end
	end
endmodule

>>> src/dsa_sign_and_verify_top.sv
// DSA sign and verify: one transaction of hash and nonce gives r, s, w, u1, u2, v
// and status. The bit-serial modular multiplier sets the run time: it works through one bit
// of its second operand per step, and is used once per exponent bit for the square and
// once more for each set bit across five modular exponentiations. Two inversions add
// Euclid steps that each take a division and one product. in_ready is high only
// between items; a finished result waits in the output register while the next item is
// taken. Status 1 with all other fields zero flags a zero modulus or a nonce or s with
// no inverse modulo q.
// Depends on dsv_pkg, dsv_ram, dsv_div and dsv_mulmod.
module dsa_sign_and_verify_top import dsv_pkg::*; #(
	parameter int MOD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] message_hash,
	input  logic [31:0] nonce,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sig_r,
	output logic [31:0] sig_s,
	output logic [31:0] inv_s,
	output logic [31:0] u_one,
	output logic [31:0] u_two,
	output logic [31:0] check_v,
	output logic        status
);
	localparam int W = MOD_BITS;

	state_t         state_q, state_d;
	logic [PC_W-1:0] pc_q;
	step_t          step;

	logic [W-1:0] prime_q, order_q, seed_q, key_q;
	logic [W-1:0] hash_q, nonce_q;
	logic [W-1:0] opa_q, opb_q, mod_q;
	logic [W-1:0] w0_q, w1_q, w2_q, w3_q;
	logic [W-1:0] res_q;
	logic [W-1:0] r_q, s_q, w_q, u1_q, u2_q, v_q;
	logic         err_q;
	logic         out_valid_q;
	logic         out_load;

	logic [W-1:0] ram_rd_a, ram_rd_b;
	logic         ram_we;

	logic         div_start, div_done;
	logic [W-1:0] div_n, div_d, div_quo, div_rem;
	logic         mul_start, mul_done;
	logic [W-1:0] mul_a, mul_b, mul_prod;
	logic [W-1:0] qred, neg;
	logic         cfg_wr;
	logic         mod_one;

	function automatic logic [W-1:0] from32(input logic [31:0] v);
		logic [W+31:0] t;
		t = {{W{1'b0}}, v};
		return t[W-1:0];
	endfunction

	function automatic logic [31:0] to32(input logic [W-1:0] v);
		logic [W+31:0] t;
		t = {32'b0, v};
		return t[31:0];
	endfunction

	function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
			input logic [W-1:0] md);
		logic [W-1:0] gap;
		gap = md - y;
		return (x >= gap) ? (x - gap) : (x + y);
	endfunction

	function automatic logic [W-1:0] src_val(input src_t s, input logic [W-1:0] ram_v,
			input logic [W-1:0] p, input logic [W-1:0] q, input logic [W-1:0] h,
			input logic [W-1:0] x, input logic [W-1:0] hm, input logic [W-1:0] k);
		logic [W-1:0] v;
		case (s)
			SRC_P:     v = p;
			SRC_Q:     v = q;
			SRC_PM1:   v = p - 1'b1;
			SRC_SEED:  v = h;
			SRC_KEY:   v = x;
			SRC_HASH:  v = hm;
			SRC_NONCE: v = k;
			SRC_NONE:  v = '0;
			default:   v = ram_v;
		endcase
		return v;
	endfunction

	assign step     = prog_step(pc_q);
	assign pready   = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign mod_one  = (mod_q == W'(1));
	assign qred     = (div_quo == mod_q) ? '0 : div_quo;
	assign neg      = (mul_prod == '0) ? '0 : (mod_q - mul_prod);

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_PRIME: prdata = to32(prime_q);
			REG_ORDER: prdata = to32(order_q);
			REG_SEED:  prdata = to32(seed_q);
			REG_KEY:   prdata = to32(key_q);
			default:   prdata = '0;
		endcase
	end

	dsv_ram #(.WIDTH(W), .DEPTH(8)) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (step.dst[2:0]),
		.wdata   (res_q),
		.raddr_a (step.a[2:0]),
		.rdata_a (ram_rd_a),
		.raddr_b (step.b[2:0]),
		.rdata_b (ram_rd_b)
	);

	dsv_div #(.W(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_n),
		.den    (div_d),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	dsv_mulmod #(.W(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.m      (mod_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_n     = opa_q;
		div_d     = opb_q;
		mul_start = 1'b0;
		mul_a     = opa_q;
		mul_b     = opb_q;
		ram_we    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (prime_q == '0 || order_q == '0) ? ST_ERR : ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_OPER;
			ST_OPER:  state_d = ST_EXEC;
			ST_EXEC: begin
				case (step.op)
					OP_QUO, OP_REM: begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
					OP_MUL: begin
						mul_start = 1'b1;
						state_d   = ST_MUL;
					end
					OP_ADD:  state_d = ST_WB;
					OP_POW:  state_d = ST_POW_CHK;
					OP_INV:  state_d = ST_INV_CHK;
					default: state_d = ST_DONE;
				endcase
			end
			ST_DIV: if (div_done) state_d = ST_WB;
			ST_MUL: if (mul_done) state_d = ST_WB;
			ST_POW_CHK: begin
				if (w2_q == '0) begin
					state_d = ST_WB;
				end else if (w2_q[0]) begin
					mul_start = 1'b1;
					mul_a     = w0_q;
					mul_b     = w1_q;
					state_d   = ST_POW_MUL;
				end else begin
					state_d = ST_POW_SQS;
				end
			end
			ST_POW_MUL: if (mul_done) state_d = ST_POW_SQS;
			ST_POW_SQS: begin
				mul_start = 1'b1;
				mul_a     = w1_q;
				mul_b     = w1_q;
				state_d   = ST_POW_SQ;
			end
			ST_POW_SQ: if (mul_done) state_d = ST_POW_CHK;
			ST_INV_CHK: begin
				if (w1_q == '0) begin
					state_d = (w0_q != W'(1)) ? ST_ERR : ST_WB;
				end else begin
					div_start = 1'b1;
					div_n     = w0_q;
					div_d     = w1_q;
					state_d   = ST_INV_DIV;
				end
			end
			ST_INV_DIV: begin
				if (div_done) begin
					mul_start = 1'b1;
					mul_a     = qred;
					mul_b     = w3_q;
					state_d   = ST_INV_MUL;
				end
			end
			ST_INV_MUL: if (mul_done) state_d = ST_INV_CHK;
			ST_WB: begin
				ram_we  = 1'b1;
				state_d = ST_FETCH;
			end
			ST_ERR: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
			prime_q     <= W'(23);
			order_q     <= W'(11);
			seed_q      <= W'(2);
			key_q       <= W'(1);
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				pc_q <= '0;
			end else if (state_q == ST_WB) begin
				pc_q <= pc_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_PRIME: prime_q <= from32(pwdata);
					REG_ORDER: order_q <= from32(pwdata);
					REG_SEED:  seed_q  <= from32(pwdata);
					REG_KEY:   key_q   <= from32(pwdata);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				hash_q  <= from32(message_hash);
				nonce_q <= from32(nonce);
				err_q   <= 1'b0;
			end
			ST_OPER: begin
				opa_q <= src_val(step.a, ram_rd_a, prime_q, order_q, seed_q, key_q,
					hash_q, nonce_q);
				opb_q <= src_val(step.b, ram_rd_b, prime_q, order_q, seed_q, key_q,
					hash_q, nonce_q);
				mod_q <= (step.m == MOD_Q) ? order_q : prime_q;
			end
			ST_EXEC: begin
				case (step.op)
					OP_POW: begin
						w0_q <= mod_one ? '0 : W'(1);
						w1_q <= opa_q;
						w2_q <= opb_q;
					end
					OP_INV: begin
						w0_q <= mod_q;
						w1_q <= opa_q;
						w2_q <= '0;
						w3_q <= mod_one ? '0 : W'(1);
					end
					OP_ADD: res_q <= add_mod(opa_q, opb_q, mod_q);
					default: ;
				endcase
			end
			ST_DIV: if (div_done) res_q <= (step.op == OP_QUO) ? div_quo : div_rem;
			ST_MUL: if (mul_done) res_q <= mul_prod;
			ST_POW_CHK: if (w2_q == '0) res_q <= w0_q;
			ST_POW_MUL: if (mul_done) w0_q <= mul_prod;
			ST_POW_SQ: begin
				if (mul_done) begin
					w1_q <= mul_prod;
					w2_q <= w2_q >> 1;
				end
			end
			ST_INV_CHK: if (w1_q == '0) res_q <= w2_q;
			ST_INV_DIV: begin
				if (div_done) begin
					w0_q <= w1_q;
					w1_q <= div_rem;
				end
			end
			ST_INV_MUL: begin
				if (mul_done) begin
					w2_q <= w3_q;
					w3_q <= add_mod(w2_q, neg, mod_q);
				end
			end
			ST_WB: begin
				case (step.o)
					OUT_R:   r_q  <= res_q;
					OUT_S:   s_q  <= res_q;
					OUT_W:   w_q  <= res_q;
					OUT_U1:  u1_q <= res_q;
					OUT_U2:  u2_q <= res_q;
					OUT_V:   v_q  <= res_q;
					default: ;
				endcase
			end
			ST_ERR: begin
				err_q <= 1'b1;
				r_q   <= '0;
				s_q   <= '0;
				w_q   <= '0;
				u1_q  <= '0;
				u2_q  <= '0;
				v_q   <= '0;
			end
			default: ;
		endcase
		if (out_load) begin
			sig_r   <= to32(r_q);
			sig_s   <= to32(s_q);
			inv_s   <= to32(w_q);
			u_one   <= to32(u1_q);
			u_two   <= to32(u2_q);
			check_v <= to32(v_q);
			status  <= err_q;
		end
	end
endmodule

>>> src/dsv_chk.sv
// Port-level checker for the DSA sign and verify block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module dsv_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] message_hash,
	input logic [31:0] nonce,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] sig_r,
	input logic [31:0] sig_s,
	input logic [31:0] inv_s,
	input logic [31:0] u_one,
	input logic [31:0] u_two,
	input logic [31:0] check_v,
	input logic        status
);
	`DSV_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(sig_r) && $stable(sig_s) && $stable(check_v) && $stable(status), "result changed while stalled")
	`DSV_ASSERT(a_err_zero, clk, arst_n, out_valid && status |-> sig_r == 32'd0 && sig_s == 32'd0 && inv_s == 32'd0 && u_one == 32'd0 && u_two == 32'd0 && check_v == 32'd0, "error result carries nonzero fields")
	`DSV_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready, "ready stayed high after a transaction")
	`DSV_ASSERT(a_no_fast_result, clk, arst_n, in_valid && in_ready |=> !$rose(out_valid), "result appeared right after accept")
	`DSV_ASSERT_ALWAYS(a_pready, clk, pready, "pready dropped")
endmodule

bind dsa_sign_and_verify_top dsv_chk u_dsv_chk (.*);

>>> verif/tb_dsa_sign_and_verify_top.sv
// Self-checking testbench for dsa_sign_and_verify_top: directed table, then random traffic.
// Predicts r, s, w, u1, u2, v and status with a local modular-arithmetic model.
// Depends on dsv_pkg and the RTL under src.
`timescale 1ns / 100ps

module tb_dsa_sign_and_verify_top import dsv_pkg::*;;

	typedef struct {
		logic [31:0] r, s, w, u1, u2, v;
		logic        err;
	} signature_t;

	typedef struct {
		int          cfg;
		logic [31:0] hash;
		logic [31:0] k;
		bit          typed;
		logic        err;
	} vector_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic in_valid = 0, in_ready;
	logic [31:0] message_hash = '0, nonce = '0;
	logic out_valid, out_ready = 0;
	logic [31:0] sig_r, sig_s, inv_s, u_one, u_two, check_v;
	logic status;

	longint unsigned prime_m = 23, order_m = 11, seed_m = 2, key_m = 1;
	signature_t pending_sigs[$];
	int errors = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	int mode_idle[4] = '{0, 79, 0, 12};
	int mode_stall[4] = '{0, 0, 79, 12};
	logic [31:0] cfg_q[5] = '{32'd3, 32'd5, 32'd7, 32'd11, 32'd13};

	logic [31:0] cfg_sets[9][4] = '{
		'{32'd23, 32'd11, 32'd2, 32'd1},
		'{32'd0, 32'd11, 32'd2, 32'd1},
		'{32'd23, 32'd0, 32'd2, 32'd1},
		'{32'd23, 32'd1, 32'd5, 32'd7},
		'{32'd7, 32'd11, 32'd3, 32'd2},
		'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
		'{32'd283, 32'd47, 32'd60, 32'd24},
		'{32'd4294967291, 32'd2147483645, 32'd2, 32'h9ABCDEF1},
		'{32'd2, 32'd2, 32'd1, 32'd0}
	};

	vector_t directed[24] = '{
		'{0, 32'd0, 32'd1, 0, 0},
		'{0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0},
		'{0, 32'd5, 32'd11, 1, 1},
		'{0, 32'd3, 32'd0, 1, 1},
		'{0, 32'd7, 32'd22, 1, 1},
		'{1, 32'd5, 32'd3, 1, 1},
		'{1, 32'd0, 32'd1, 1, 1},
		'{2, 32'd5, 32'd3, 1, 1},
		'{3, 32'd123, 32'd456, 0, 0},
		'{4, 32'd9, 32'd4, 0, 0},
		'{4, 32'hFFFFFFFF, 32'd1, 0, 0},
		'{5, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0},
		'{5, 32'd0, 32'h80000000, 0, 0},
		'{6, 32'd41, 32'd15, 0, 0},
		'{6, 32'd0, 32'd1, 0, 0},
		'{6, 32'd46, 32'd47, 1, 1},
		'{6, 32'd100, 32'd48, 0, 0},
		'{6, 32'h55555555, 32'hAAAAAAAA, 0, 0},
		'{7, 32'hDEADBEEF, 32'h12345677, 0, 0},
		'{7, 32'd1, 32'hFFFFFFFE, 0, 0},
		'{8, 32'd0, 32'd1, 0, 0},
		'{8, 32'd1, 32'd1, 0, 0},
		'{8, 32'd3, 32'd2, 1, 1},
		'{8, 32'hFFFFFFFF, 32'd3, 0, 0}
	};

	dsa_sign_and_verify_top dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	initial begin
		#40000000;
		$display("dsa_sign_and_verify_top test failed");
		$finish;
	end

	function automatic longint unsigned mulm(longint unsigned a, longint unsigned b,
			longint unsigned m);
		return ((a % m) * (b % m)) % m;
	endfunction

	function automatic longint unsigned powm(longint unsigned b, longint unsigned e,
			longint unsigned m);
		longint unsigned acc;
		acc = 1 % m;
		b = b % m;
		while (e != 0) begin
			if (e[0])
				acc = mulm(acc, b, m);
			b = mulm(b, b, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic longint unsigned invm(longint unsigned a, longint unsigned m,
			output bit ok);
		longint unsigned r0, r1, t0, t1, qt, rn, tn;
		ok = 1;
		if (m == 1)
			return 0;
		r0 = m;
		r1 = a % m;
		t0 = 0;
		t1 = 1;
		while (r1 != 0) begin
			qt = r0 / r1;
			rn = r0 % r1;
			tn = (t0 + (m - mulm(qt, t1, m))) % m;
			r0 = r1;
			r1 = rn;
			t0 = t1;
			t1 = tn;
		end
		if (r0 != 1) begin
			ok = 0;
			return 0;
		end
		return t0;
	endfunction

	function automatic signature_t sign_and_verify(logic [31:0] hash, logic [31:0] k);
		signature_t sg;
		longint unsigned p, q, g, r, kinv, s, w, u1, u2, y, v;
		bit ok;
		sg = '{default: '0};
		p = prime_m;
		q = order_m;
		if (p == 0 || q == 0) begin
			sg.err = 1;
			return sg;
		end
		g = powm(seed_m, (p - 1) / q, p);
		r = powm(g, 64'(k), p) % q;
		kinv = invm(64'(k), q, ok);
		if (!ok) begin
			sg.err = 1;
			return sg;
		end
		s = mulm(kinv, (64'(hash) % q + mulm(key_m, r, q)) % q, q);
		w = invm(s, q, ok);
		if (!ok) begin
			sg.err = 1;
			return sg;
		end
		u1 = mulm(64'(hash), w, q);
		u2 = mulm(r, w, q);
		y = powm(g, key_m, p);
		v = mulm(powm(g, u1, p), powm(y, u2, p), p) % q;
		sg.r = 32'(r);
		sg.s = 32'(s);
		sg.w = 32'(w);
		sg.u1 = 32'(u1);
		sg.u2 = 32'(u2);
		sg.v = 32'(v);
		return sg;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_PRIME: prime_m = 64'(value);
			REG_ORDER: order_m = 64'(value);
			REG_SEED:  seed_m = 64'(value);
			REG_KEY:   key_m = 64'(value);
			default: ;
		endcase
	endtask

	task automatic drain();
		if (in_valid)
			in_valid <= 0;
		@(posedge clk);
		while (pending_sigs.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_config(logic [31:0] p, logic [31:0] q, logic [31:0] h,
			logic [31:0] x);
		drain();
		write_reg(REG_PRIME, p);
		write_reg(REG_ORDER, q);
		write_reg(REG_SEED, h);
		write_reg(REG_KEY, x);
	endtask

	task automatic send(logic [31:0] hash, logic [31:0] k, bit typed, logic err);
		signature_t sg;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		message_hash <= hash;
		nonce <= k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (typed) begin
			sg = '{default: '0};
			sg.err = err;
		end else
			sg = sign_and_verify(hash, k);
		pending_sigs.push_back(sg);
	endtask

	always @(posedge clk) begin
		signature_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_sigs.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				e = pending_sigs.pop_front();
				if (sig_r !== e.r) begin
					$error("sig_r exp %h got %h", e.r, sig_r);
					errors++;
				end
				if (sig_s !== e.s) begin
					$error("sig_s exp %h got %h", e.s, sig_s);
					errors++;
				end
				if (inv_s !== e.w) begin
					$error("inv_s exp %h got %h", e.w, inv_s);
					errors++;
				end
				if (u_one !== e.u1) begin
					$error("u_one exp %h got %h", e.u1, u_one);
					errors++;
				end
				if (u_two !== e.u2) begin
					$error("u_two exp %h got %h", e.u2, u_two);
					errors++;
				end
				if (check_v !== e.v) begin
					$error("check_v exp %h got %h", e.v, check_v);
					errors++;
				end
				if (status !== e.err) begin
					$error("status exp %b got %b", e.err, status);
					errors++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		int cur_cfg;
		logic [31:0] k;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		cur_cfg = 0;
		foreach (directed[i]) begin
			if (directed[i].cfg != cur_cfg) begin
				cur_cfg = directed[i].cfg;
				load_config(cfg_sets[cur_cfg][0], cfg_sets[cur_cfg][1],
					cfg_sets[cur_cfg][2], cfg_sets[cur_cfg][3]);
			end
			send(directed[i].hash, directed[i].k, directed[i].typed, directed[i].err);
		end
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: load_config(32'd283, 32'd47, $urandom, $urandom);
				1: load_config(32'd4294967291, 32'd2147483645, $urandom, $urandom);
				2: load_config($urandom, $urandom_range(32'hFFFFFFFF, 1), $urandom, $urandom);
				default: load_config($urandom | 32'd1, cfg_q[$urandom_range(4)],
					$urandom, $urandom);
			endcase
			send_idle_pct = mode_idle[ph];
			recv_stall_pct = mode_stall[ph];
			for (int n = 0; n < 25; n++) begin
				k = ($urandom_range(1)) ? $urandom : $urandom_range(1000, 1);
				send($urandom, k, 0, 0);
			end
		end
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("dsa_sign_and_verify_top test passed");
		else
			$display("dsa_sign_and_verify_top test failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/dsv_pkg.sv
src/dsv_ram.sv
src/dsv_div.sv
src/dsv_mulmod.sv
src/dsa_sign_and_verify_top.sv
src/dsv_chk.sv
verif/tb_dsa_sign_and_verify_top.sv
